// ===== sv/eaq_pkg.sv =====
package eaq_pkg;

    localparam int ANGLE_BITS_DEF     = 16;
    localparam int COMPONENT_BITS_DEF = 16;
    localparam int CORDIC_STEPS_DEF   = 16;

    localparam int MAX_STEPS = 32;
    localparam int FRAC_BITS = 30;
    localparam longint GAIN_Q30 = 64'sd652032874;

    // Rotation angle of each step, atan(2^-i), with 2^34 per full turn.
    function automatic longint atan_entry(input int idx);
        longint v;
        v = 64'sd0;
        case (idx)
            0:  v = 64'sd2147483648;
            1:  v = 64'sd1267733622;
            2:  v = 64'sd669835630;
            3:  v = 64'sd340019025;
            4:  v = 64'sd170669324;
            5:  v = 64'sd85417861;
            6:  v = 64'sd42719353;
            7:  v = 64'sd21360980;
            8:  v = 64'sd10680653;
            9:  v = 64'sd5340347;
            10: v = 64'sd2670176;
            11: v = 64'sd1335088;
            12: v = 64'sd667544;
            13: v = 64'sd333772;
            14: v = 64'sd166886;
            15: v = 64'sd83443;
            16: v = 64'sd41722;
            17: v = 64'sd20861;
            18: v = 64'sd10430;
            19: v = 64'sd5215;
            20: v = 64'sd2608;
            21: v = 64'sd1304;
            22: v = 64'sd652;
            23: v = 64'sd326;
            24: v = 64'sd163;
            25: v = 64'sd81;
            26: v = 64'sd41;
            27: v = 64'sd20;
            28: v = 64'sd10;
            29: v = 64'sd5;
            30: v = 64'sd3;
            31: v = 64'sd1;
            default: v = 64'sd0;
        endcase
        return v;
    endfunction

endpackage

// ===== sv/eaq_if.sv =====
interface eaq_angle_if #(
    parameter int ANGLE_BITS = eaq_pkg::ANGLE_BITS_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic signed [ANGLE_BITS-1:0]  roll_angle;
    logic signed [ANGLE_BITS-1:0]  pitch_angle;
    logic signed [ANGLE_BITS-1:0]  yaw_angle;

    modport source (output valid, output roll_angle, output pitch_angle, output yaw_angle,
                    input ready);
    modport sink   (input valid, input roll_angle, input pitch_angle, input yaw_angle,
                    output ready);
endinterface

interface eaq_quat_if #(
    parameter int COMPONENT_BITS = eaq_pkg::COMPONENT_BITS_DEF
) ();
    logic                             valid;
    logic                             ready;
    logic signed [COMPONENT_BITS-1:0] quat_w;
    logic signed [COMPONENT_BITS-1:0] quat_x;
    logic signed [COMPONENT_BITS-1:0] quat_y;
    logic signed [COMPONENT_BITS-1:0] quat_z;

    modport source (output valid, output quat_w, output quat_x, output quat_y, output quat_z,
                    input ready);
    modport sink   (input valid, input quat_w, input quat_x, input quat_y, input quat_z,
                    output ready);
endinterface

// ===== sv/euler_angles_to_quaternion.sv =====
// Converts roll, pitch and yaw binary angles (a full turn is 2^ANGLE_BITS) into the ZYX
// unit quaternion w, x, y, z in signed Q1.(COMPONENT_BITS-1), with +1.0 saturated to the
// largest positive code. The block takes one item per clock cycle while the output is not
// held. Each item passes one input register, one register per unrolled CORDIC step for the
// three half-angle sine/cosine lanes, then two multiply stages, a sum stage and a
// round/saturate stage that is also the output register. When the output is held, all
// stages stall together and the input is not ready until the output moves.
module euler_angles_to_quaternion #(
    parameter int ANGLE_BITS     = eaq_pkg::ANGLE_BITS_DEF,
    parameter int COMPONENT_BITS = eaq_pkg::COMPONENT_BITS_DEF,
    parameter int CORDIC_STEPS   = eaq_pkg::CORDIC_STEPS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    eaq_angle_if.sink   i_angle,
    eaq_quat_if.source  o_quat
);

    localparam int NSTEPS = (CORDIC_STEPS > eaq_pkg::MAX_STEPS) ? eaq_pkg::MAX_STEPS
                                                                 : CORDIC_STEPS;
    localparam int LAST   = NSTEPS + 4;
    localparam int XW     = 34;
    localparam int ZW     = 36;
    localparam int CW     = 32;
    localparam int PW     = 34;
    localparam int TW     = PW + CW;
    localparam int SW     = TW + 1;
    localparam int VW     = SW + 1;
    localparam int SHIFT  = 61 - COMPONENT_BITS;
    localparam int ZSH    = 33 - ANGLE_BITS;

    localparam logic signed [XW-1:0] GAIN    = XW'(eaq_pkg::GAIN_Q30);
    localparam logic signed [VW-1:0] RND     = VW'(64'sd1 <<< (SHIFT - 1));
    localparam logic signed [VW-1:0] SAT_HI  = VW'((64'sd1 <<< (COMPONENT_BITS - 1)) - 64'sd1);
    localparam logic signed [VW-1:0] SAT_LO  = VW'(-(64'sd1 <<< (COMPONENT_BITS - 1)));

    logic              en;
    logic [LAST:0]     r_vld;

    logic signed [XW-1:0] r_x [NSTEPS+1][3];
    logic signed [XW-1:0] r_y [NSTEPS+1][3];
    logic signed [ZW-1:0] r_z [NSTEPS+1][3];

    logic signed [CW-1:0] cx, sx, cy, sy, cz, sz;

    logic signed [PW-1:0] r_czcy, r_szsy, r_czsy, r_szcy;
    logic signed [CW-1:0] r_cx, r_sx;
    logic signed [TW-1:0] r_t [8];
    logic signed [SW-1:0] r_sum [4];
    logic signed [COMPONENT_BITS-1:0] r_q [4];

    logic signed [2*CW-1:0] m_czcy, m_szsy, m_czsy, m_szcy;
    logic signed [TW-1:0]   n_t [8];

    assign en            = !r_vld[LAST] || o_quat.ready;
    assign i_angle.ready = en;
    assign o_quat.valid  = r_vld[LAST];
    assign o_quat.quat_w = r_q[0];
    assign o_quat.quat_x = r_q[1];
    assign o_quat.quat_y = r_q[2];
    assign o_quat.quat_z = r_q[3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAST-1:0], i_angle.valid};
        end
    end

    // Half angle, 2^34 per turn.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x[0][0] <= GAIN;
            r_x[0][1] <= GAIN;
            r_x[0][2] <= GAIN;
            r_y[0][0] <= '0;
            r_y[0][1] <= '0;
            r_y[0][2] <= '0;
            r_z[0][0] <= ZW'(i_angle.roll_angle) <<< ZSH;
            r_z[0][1] <= ZW'(i_angle.pitch_angle) <<< ZSH;
            r_z[0][2] <= ZW'(i_angle.yaw_angle) <<< ZSH;
        end
    end

    for (genvar i = 0; i < NSTEPS; i++) begin : g_step
        localparam logic signed [ZW-1:0] ATAN = ZW'(eaq_pkg::atan_entry(i));
        for (genvar j = 0; j < 3; j++) begin : g_lane
            logic signed [XW-1:0] dx, dy, n_x, n_y;
            logic signed [ZW-1:0] n_z;

            always_comb begin
                dx = r_y[i][j] >>> i;
                dy = r_x[i][j] >>> i;
                if (!r_z[i][j][ZW-1]) begin
                    n_x = r_x[i][j] - dx;
                    n_y = r_y[i][j] + dy;
                    n_z = r_z[i][j] - ATAN;
                end else begin
                    n_x = r_x[i][j] + dx;
                    n_y = r_y[i][j] - dy;
                    n_z = r_z[i][j] + ATAN;
                end
            end

            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_x[i+1][j] <= n_x;
                    r_y[i+1][j] <= n_y;
                    r_z[i+1][j] <= n_z;
                end
            end
        end
    end

    assign cx = CW'(r_x[NSTEPS][0]);
    assign sx = CW'(r_y[NSTEPS][0]);
    assign cy = CW'(r_x[NSTEPS][1]);
    assign sy = CW'(r_y[NSTEPS][1]);
    assign cz = CW'(r_x[NSTEPS][2]);
    assign sz = CW'(r_y[NSTEPS][2]);

    assign m_czcy = cz * cy;
    assign m_szsy = sz * sy;
    assign m_czsy = cz * sy;
    assign m_szcy = sz * cy;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_czcy <= PW'(m_czcy >>> eaq_pkg::FRAC_BITS);
            r_szsy <= PW'(m_szsy >>> eaq_pkg::FRAC_BITS);
            r_czsy <= PW'(m_czsy >>> eaq_pkg::FRAC_BITS);
            r_szcy <= PW'(m_szcy >>> eaq_pkg::FRAC_BITS);
            r_cx   <= cx;
            r_sx   <= sx;
        end
    end

    assign n_t[0] = r_czcy * r_cx;
    assign n_t[1] = r_szsy * r_sx;
    assign n_t[2] = r_czcy * r_sx;
    assign n_t[3] = r_szsy * r_cx;
    assign n_t[4] = r_czsy * r_cx;
    assign n_t[5] = r_szcy * r_sx;
    assign n_t[6] = r_szcy * r_cx;
    assign n_t[7] = r_czsy * r_sx;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_t      <= n_t;
            r_sum[0] <= SW'(r_t[0]) + SW'(r_t[1]);
            r_sum[1] <= SW'(r_t[2]) - SW'(r_t[3]);
            r_sum[2] <= SW'(r_t[4]) + SW'(r_t[5]);
            r_sum[3] <= SW'(r_t[6]) - SW'(r_t[7]);
        end
    end

    for (genvar k = 0; k < 4; k++) begin : g_out
        logic signed [VW-1:0] rnd;

        assign rnd = (VW'(r_sum[k]) + RND) >>> SHIFT;

        always_ff @(posedge i_clk) begin
            if (en) begin
                if (rnd > SAT_HI) begin
                    r_q[k] <= COMPONENT_BITS'(SAT_HI);
                end else if (rnd < SAT_LO) begin
                    r_q[k] <= COMPONENT_BITS'(SAT_LO);
                end else begin
                    r_q[k] <= COMPONENT_BITS'(rnd);
                end
            end
        end
    end

endmodule
